[design/cer_pkg.sv]
// shared types and codes for the coalescing event ring
`timescale 1ns / 1ps

package cer_pkg;

  // default ring size
  localparam int DEFAULT_RING_DEPTH = 256;

  // saturation limit of an entry count
  localparam logic [15:0] COUNT_MAX = 16'hffff;

  // result status codes
  localparam logic [1:0] ST_PLACED = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_POPPED = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // one ring entry, count of zero marks a free slot
  typedef struct packed {
    logic [15:0] count;
    logic [7:0]  flags;
    logic [7:0]  code;
  } entry_t;

endpackage

[design/cer_ram.sv]
// single write port, single registered read port ring storage
`timescale 1ns / 1ps

module cer_ram #(
  parameter int RING_DEPTH = cer_pkg::DEFAULT_RING_DEPTH,
  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  cer_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output cer_pkg::entry_t rd_data
);
  import cer_pkg::*;

  entry_t mem [RING_DEPTH];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/coalescing_event_ring.sv]
// coalescing event ring: top level with sequencer and shared merge unit
`timescale 1ns / 1ps

// sequence: a pop goes through S_POP and S_DONE; a push goes through S_PREV and, if a
//   remainder is left, S_SCAN (one entry per cycle, up to the whole ring) before S_DONE
// throughput: one item at a time; the next input transfer waits until the sequencer is
//   back in S_IDLE after S_DONE hands over the result; a stalled result holds the sequencer
// reset: synchronous active low; afterwards a clearing pass writes every entry
//   to zero, during which in_tready stays low
module coalescing_event_ring #(
  parameter int RING_DEPTH = cer_pkg::DEFAULT_RING_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // event_code[7:0], flags_in[15:8], count_in[31:16]
  input  logic [0:0]  in_tuser,   // cmd[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // code_out[7:0], flags_out[15:8], count_out[31:16]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import cer_pkg::*;

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  // sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_PREV = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] n_r, n_nxt;
  logic [7:0]    code_r, code_nxt;
  logic [7:0]    flags_r, flags_nxt;
  logic [15:0]   rest_r, rest_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  entry_t        res_entry_r, res_entry_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_data_r, out_data_nxt;
  logic [1:0]    out_user_r, out_user_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;

  // shared merge unit signals
  logic          slot_free;
  logic          slot_match;
  logic [15:0]   room;
  logic          over;
  entry_t        merged;
  logic [15:0]   merge_rest;

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
    ring_prev = (p == '0) ? LAST_IDX : p - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == LAST_IDX) ? '0 : p + AW'(1);
  endfunction

  cer_ram #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // merge of the pending remainder into the entry just read
  always_comb begin
    slot_free  = (rd_data.count == '0);
    slot_match = !slot_free && (rd_data.code == code_r) && (rd_data.flags == flags_r)
                 && (rd_data.count != COUNT_MAX);
    room       = COUNT_MAX - rd_data.count;
    over       = (rest_r > room);
    merged     = rd_data;
    merged.count = over ? COUNT_MAX : rd_data.count + rest_r;
    merge_rest = over ? rest_r - room : '0;
  end

  assign in_tready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    pos_nxt        = pos_r;
    n_nxt          = n_r;
    code_nxt       = code_r;
    flags_nxt      = flags_r;
    rest_nxt       = rest_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_data        = '0;
    rd_addr        = rp_r;

    // output register drains independently
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // zero one entry per cycle after reset
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        pos_nxt = ring_next(pos_r);
        if (pos_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      // take an item and launch its first read
      S_IDLE: begin
        code_nxt  = in_tdata[7:0];
        flags_nxt = in_tdata[15:8];
        rest_nxt  = in_tdata[31:16];
        if (in_tuser[0] == CMD_POP) begin
          rd_addr = rp_r;
        end else begin
          rd_addr = ring_prev(wp_r);
        end
        if (in_tvalid) begin
          state_nxt = (in_tuser[0] == CMD_POP) ? S_POP : S_PREV;
        end
      end

      // oldest entry is on the read port
      S_POP: begin
        res_entry_nxt = '0;
        if (!slot_free) begin
          wr_en          = 1'b1;
          wr_addr        = rp_r;
          wr_data        = '0;
          rp_nxt         = ring_next(rp_r);
          res_status_nxt = ST_POPPED;
          res_entry_nxt  = rd_data;
        end else begin
          res_status_nxt = ST_EMPTY;
        end
        state_nxt = S_DONE;
      end

      // entry before the write pointer, then start the scan at the write pointer
      S_PREV: begin
        if (slot_match) begin
          wr_en    = 1'b1;
          wr_addr  = ring_prev(wp_r);
          wr_data  = merged;
          rest_nxt = merge_rest;
        end
        rd_addr       = wp_r;
        pos_nxt       = wp_r;
        n_nxt         = '0;
        res_entry_nxt = '0;
        if ((slot_match ? merge_rest : rest_r) == '0) begin
          res_status_nxt = ST_PLACED;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      // one slot per cycle, walking backwards from the write pointer
      S_SCAN: begin
        rd_addr = ring_prev(pos_r);
        pos_nxt = ring_prev(pos_r);
        n_nxt   = n_r + AW'(1);
        if (slot_free) begin
          wr_en         = 1'b1;
          wr_addr       = pos_r;
          wr_data.code  = code_r;
          wr_data.flags = flags_r;
          wr_data.count = rest_r;
          wp_nxt        = ring_next(wp_r);
          rest_nxt      = '0;
        end else if ((pos_r != rp_r) && slot_match) begin
          wr_en    = 1'b1;
          wr_addr  = pos_r;
          wr_data  = merged;
          rest_nxt = merge_rest;
        end
        res_entry_nxt       = '0;
        res_entry_nxt.count = rest_nxt;
        res_status_nxt      = (rest_nxt != '0) ? ST_FULL : ST_PLACED;
        if ((rest_nxt == '0) || (n_r == LAST_IDX)) begin
          state_nxt = S_DONE;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_entry_r;
          out_user_nxt  = res_status_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      rp_r        <= '0;
      wp_r        <= '0;
      pos_r       <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      pos_r       <= pos_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    code_r       <= code_nxt;
    flags_r      <= flags_nxt;
    rest_r       <= rest_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[design/cer_checker.sv]
// port-level checker for the coalescing event ring and its bind
`timescale 1ns / 1ps

module cer_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import cer_pkg::*;

  // a popped entry is never a free slot
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_POPPED) |-> out_tdata[31:16] != '0)
    else $error("popped entry with zero count");

  // push results carry no code or flags
  a_push_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == ST_PLACED) || (out_tuser == ST_FULL))
    |-> out_tdata[15:0] == '0)
    else $error("push result with nonzero code or flags");

  // a full status always returns a remainder
  a_full_rest: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |-> out_tdata[31:16] != '0)
    else $error("full status without remainder");

  // empty and placed results carry no count
  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == ST_EMPTY) || (out_tuser == ST_PLACED))
    |-> out_tdata == '0)
    else $error("empty or placed result with nonzero data");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind coalescing_event_ring cer_checker u_cer_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
